>>> src/cfrx_pkg.sv
// Shared types and constants for the command frame receiver.
// Used by the receiver top level and its port checker.
`timescale 1ns / 1ps
`default_nettype none

package cfrx_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned KindW  = 3;
    localparam int unsigned IndexW = 6;
    localparam int unsigned RegIdxW = 2;

    localparam logic [ByteW-1:0] LenSelect   = 8'd9;
    localparam logic [ByteW-1:0] LenRead     = 8'd11;
    localparam logic [ByteW-1:0] LenWriteMin = 8'd14;
    localparam logic [ByteW-1:0] LenWriteMax = 8'd42;

    localparam logic [IndexW-1:0] MaxPayloadIndex = 6'd41;

    localparam logic [ByteW-1:0] ResetFirstCmd = 8'd1;
    localparam logic [ByteW-1:0] ResetResendA  = 8'd224;
    localparam logic [ByteW-1:0] ResetResendB  = 8'd225;
    localparam logic [ByteW-1:0] ResetResendC  = 8'd226;

    typedef enum logic [RegIdxW-1:0] {
        REG_FIRST_CMD = 2'd0,
        REG_RESEND_A  = 2'd1,
        REG_RESEND_B  = 2'd2,
        REG_RESEND_C  = 2'd3
    } reg_index_t;

    typedef enum logic [KindW-1:0] {
        EV_PAYLOAD   = 3'd0,
        EV_FRAME_OK  = 3'd1,
        EV_CHECK_ERR = 3'd2,
        EV_COUNT_ERR = 3'd3,
        EV_CMD_ERR   = 3'd4,
        EV_RESEND    = 3'd5,
        EV_TIMEOUT   = 3'd6
    } event_kind_t;

    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_TIMEOUT = 1'b1
    } opcode_t;

endpackage

`default_nettype wire

>>> src/command_frame_receiver_xor_check_unit.sv
// Command frame receiver with XOR checksum: frame parser and result register.
// Depends on cfrx_pkg.
//
// Takes one transaction (a received byte or a timeout event) in every clock cycle while
// s_ready is high and reports at most one result per transaction, in the cycle after
// acceptance, from a result register. s_ready falls only while a result waits in that
// register and m_ready is low; all parsing runs in a single pass from the frame state
// registers. Configuration writes on cfg_wr_en are registered and have no handshake.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_receiver_xor_check_unit import cfrx_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [RegIdxW-1:0] cfg_index,
    input  wire logic [ByteW-1:0]   cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_opcode,
    input  wire logic [ByteW-1:0]   s_rx_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [KindW-1:0]        m_event_kind,
    output logic [ByteW-1:0]        m_command_code,
    output logic [ByteW-1:0]        m_frame_length,
    output logic [ByteW-1:0]        m_payload_byte,
    output logic [IndexW-1:0]       m_payload_index
);

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_LEN         = 3'd1,
        PH_DATA        = 3'd2,
        PH_CHECK       = 3'd3,
        PH_SWALLOW_CMD = 3'd4,
        PH_SWALLOW_CNT = 3'd5
    } phase_t;

    logic [ByteW-1:0] first_cmd_reg;
    logic [ByteW-1:0] resend_a_reg;
    logic [ByteW-1:0] resend_b_reg;
    logic [ByteW-1:0] resend_c_reg;

    phase_t            phase_reg, phase_next;
    logic [ByteW-1:0]  cmd_reg, cmd_next;
    logic [ByteW-1:0]  len_reg, len_next;
    logic [IndexW-1:0] count_reg, count_next;
    logic [ByteW-1:0]  xor_reg, xor_next;

    logic              out_valid_reg, out_valid_next;
    event_kind_t       kind_reg, kind_next;
    logic [ByteW-1:0]  out_cmd_reg, out_len_reg;
    logic [ByteW-1:0]  pbyte_reg, pbyte_next;
    logic [IndexW-1:0] pidx_reg, pidx_next;

    logic              accept;
    logic              has_result;
    logic              in_range;
    logic              is_resend;
    logic              len_ok;
    logic [ByteW:0]    last_cmd;
    logic [ByteW-1:0]  cmd_offset;
    logic [IndexW-1:0] count_inc;
    logic [ByteW-1:0]  b;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign b       = s_rx_byte;

    assign last_cmd   = {1'b0, first_cmd_reg} + (ByteW+1)'(4);
    assign in_range   = (b >= first_cmd_reg) && ({1'b0, b} <= last_cmd);
    assign is_resend  = (b == resend_a_reg) || (b == resend_b_reg) || (b == resend_c_reg);
    assign cmd_offset = cmd_reg - first_cmd_reg;
    assign count_inc  = count_reg + IndexW'(1);

    always_comb begin
        unique case (cmd_offset)
            8'd1:    len_ok = (b == LenSelect);
            8'd2:    len_ok = (b == LenRead);
            8'd3:    len_ok = (b >= LenWriteMin) && (b <= LenWriteMax);
            default: len_ok = (b == '0);
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        has_result = 1'b0;
        kind_next  = EV_PAYLOAD;
        pbyte_next = '0;
        pidx_next  = '0;
        if (s_opcode == OP_TIMEOUT) begin
            unique case (phase_reg)
                PH_LEN, PH_DATA, PH_CHECK: begin
                    has_result = 1'b1;
                    kind_next  = EV_TIMEOUT;
                end
                PH_SWALLOW_CMD: begin
                    has_result = 1'b1;
                    kind_next  = EV_CMD_ERR;
                end
                PH_SWALLOW_CNT: begin
                    has_result = 1'b1;
                    kind_next  = EV_COUNT_ERR;
                end
                default: has_result = 1'b0;
            endcase
            phase_next = PH_IDLE;
        end else begin
            unique case (phase_reg)
                PH_LEN: begin
                    len_next   = b;
                    xor_next   = xor_reg ^ b;
                    count_next = '0;
                    if (!len_ok) begin
                        phase_next = PH_SWALLOW_CNT;
                    end else if (b == '0) begin
                        phase_next = PH_CHECK;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    has_result = 1'b1;
                    kind_next  = EV_PAYLOAD;
                    pbyte_next = b;
                    pidx_next  = count_reg;
                    xor_next   = xor_reg ^ b;
                    count_next = count_inc;
                    if ({{(ByteW-IndexW){1'b0}}, count_inc} == len_reg) begin
                        phase_next = PH_CHECK;
                        count_next = '0;
                    end
                end
                PH_CHECK: begin
                    has_result = 1'b1;
                    kind_next  = (b == xor_reg) ? EV_FRAME_OK : EV_CHECK_ERR;
                    phase_next = PH_IDLE;
                end
                PH_SWALLOW_CMD, PH_SWALLOW_CNT: begin
                    phase_next = phase_reg;
                end
                default: begin
                    cmd_next   = b;
                    len_next   = '0;
                    count_next = '0;
                    xor_next   = b;
                    if (in_range) begin
                        phase_next = PH_LEN;
                    end else if (is_resend) begin
                        has_result = 1'b1;
                        kind_next  = EV_RESEND;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_SWALLOW_CMD;
                    end
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (accept && has_result) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_cmd_reg <= ResetFirstCmd;
            resend_a_reg  <= ResetResendA;
            resend_b_reg  <= ResetResendB;
            resend_c_reg  <= ResetResendC;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_FIRST_CMD: first_cmd_reg <= cfg_wdata;
                REG_RESEND_A:  resend_a_reg  <= cfg_wdata;
                REG_RESEND_B:  resend_b_reg  <= cfg_wdata;
                REG_RESEND_C:  resend_c_reg  <= cfg_wdata;
                default:       first_cmd_reg <= first_cmd_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            cmd_reg       <= '0;
            len_reg       <= '0;
            count_reg     <= '0;
            xor_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                phase_reg <= phase_next;
                cmd_reg   <= cmd_next;
                len_reg   <= len_next;
                count_reg <= count_next;
                xor_reg   <= xor_next;
            end
        end
    end

    // hold the result payload until a new result is loaded
    always_ff @(posedge aclk) begin
        if (accept && has_result) begin
            kind_reg    <= kind_next;
            out_cmd_reg <= cmd_next;
            out_len_reg <= len_next;
            pbyte_reg   <= pbyte_next;
            pidx_reg    <= pidx_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_event_kind    = kind_reg;
    assign m_command_code  = out_cmd_reg;
    assign m_frame_length  = out_len_reg;
    assign m_payload_byte  = pbyte_reg;
    assign m_payload_index = pidx_reg;

endmodule

`default_nettype wire

>>> src/cfrx_checker.sv
// Port-level checks for the command frame receiver, bound to the top level.
// Depends on cfrx_pkg and command_frame_receiver_xor_check_unit.
`timescale 1ns / 1ps
`default_nettype none

module cfrx_checker import cfrx_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [KindW-1:0]  m_event_kind,
    input wire logic [ByteW-1:0]  m_frame_length,
    input wire logic [ByteW-1:0]  m_payload_byte,
    input wire logic [IndexW-1:0] m_payload_index
);

    // no result may survive reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result keeps its kind
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind))
        else $error("stalled result changed");

    // drop ready only while a result is pending
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("ready low with empty result register");

    a_payload_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != EV_PAYLOAD |->
            m_payload_byte == '0 && m_payload_index == '0)
        else $error("payload fields set on non-payload result");

    a_payload_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == EV_PAYLOAD |->
            m_payload_index <= MaxPayloadIndex && m_frame_length != '0)
        else $error("payload result outside frame length");

endmodule

bind command_frame_receiver_xor_check_unit cfrx_checker u_cfrx_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_event_kind    (m_event_kind),
    .m_frame_length  (m_frame_length),
    .m_payload_byte  (m_payload_byte),
    .m_payload_index (m_payload_index)
);

`default_nettype wire

>>> test/cfrx_event_checker.sv
// Command offsets shared by the testbench, and the port checker for the frame receiver.
// Follows the register port and both channels, parses the byte stream itself and
// compares every result transaction field by field. Depends on cfrx_pkg.
`timescale 1ns / 1ps

package cfrx_tb_pkg;
    import cfrx_pkg::*;

    typedef enum logic [ByteW-1:0] {
        CMD_SCAN    = 8'd0,
        CMD_SELECT  = 8'd1,
        CMD_READ    = 8'd2,
        CMD_WRITE   = 8'd3,
        CMD_VERSION = 8'd4
    } command_t;
endpackage

module cfrx_event_checker
    import cfrx_pkg::*;
    import cfrx_tb_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [RegIdxW-1:0] cfg_index,
    input  wire logic [ByteW-1:0]   cfg_wdata,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic               s_opcode,
    input  wire logic [ByteW-1:0]   s_rx_byte,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [KindW-1:0]   m_event_kind,
    input  wire logic [ByteW-1:0]   m_command_code,
    input  wire logic [ByteW-1:0]   m_frame_length,
    input  wire logic [ByteW-1:0]   m_payload_byte,
    input  wire logic [IndexW-1:0]  m_payload_index,
    output int unsigned             mismatches,
    output int unsigned             pending,
    output int unsigned             results_checked,
    output int unsigned             frames_passed
);

    typedef enum logic [2:0] {
        RX_IDLE     = 3'd0,
        RX_LENGTH   = 3'd1,
        RX_PAYLOAD  = 3'd2,
        RX_CHECKSUM = 3'd3,
        RX_SKIP_CMD = 3'd4,
        RX_SKIP_LEN = 3'd5
    } rx_phase_t;

    typedef struct packed {
        event_kind_t       kind;
        logic [ByteW-1:0]  cmd;
        logic [ByteW-1:0]  len;
        logic [ByteW-1:0]  data;
        logic [IndexW-1:0] idx;
    } rx_event_t;

    rx_phase_t         phase;
    logic [ByteW-1:0]  first_cmd;
    logic [ByteW-1:0]  resend_a;
    logic [ByteW-1:0]  resend_b;
    logic [ByteW-1:0]  resend_c;
    logic [ByteW-1:0]  frame_cmd;
    logic [ByteW-1:0]  frame_len;
    logic [ByteW-1:0]  xor_acc;
    logic [IndexW-1:0] taken;
    rx_event_t         events_due[$];

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t ns] mismatch: %s", $time, what);
        end
    endtask

    task automatic queue_event(input event_kind_t kind, input logic [ByteW-1:0] data,
                               input logic [IndexW-1:0] idx);
        rx_event_t ev;
        ev.kind = kind;
        ev.cmd  = frame_cmd;
        ev.len  = frame_len;
        ev.data = data;
        ev.idx  = idx;
        events_due.push_back(ev);
    endtask

    task automatic parse_rx_transaction(input opcode_t op, input logic [ByteW-1:0] b);
        command_t which;
        logic     len_good;
        if (op == OP_TIMEOUT) begin
            case (phase)
                RX_IDLE: ;
                RX_SKIP_CMD: queue_event(EV_CMD_ERR, '0, '0);
                RX_SKIP_LEN: queue_event(EV_COUNT_ERR, '0, '0);
                default: queue_event(EV_TIMEOUT, '0, '0);
            endcase
            phase = RX_IDLE;
        end else begin
            case (phase)
                RX_LENGTH: begin
                    which     = command_t'(frame_cmd - first_cmd);
                    frame_len = b;
                    xor_acc   = xor_acc ^ b;
                    taken     = '0;
                    case (which)
                        CMD_SELECT: len_good = (b == LenSelect);
                        CMD_READ:   len_good = (b == LenRead);
                        CMD_WRITE:  len_good = (b >= LenWriteMin) && (b <= LenWriteMax);
                        default:    len_good = (b == '0);
                    endcase
                    if (!len_good) begin
                        phase = RX_SKIP_LEN;
                    end else if (b == '0) begin
                        phase = RX_CHECKSUM;
                    end else begin
                        phase = RX_PAYLOAD;
                    end
                end
                RX_PAYLOAD: begin
                    queue_event(EV_PAYLOAD, b, taken);
                    xor_acc = xor_acc ^ b;
                    taken   = taken + 1'b1;
                    if ({2'b00, taken} == frame_len) begin
                        phase = RX_CHECKSUM;
                        taken = '0;
                    end
                end
                RX_CHECKSUM: begin
                    if (b == xor_acc) begin
                        queue_event(EV_FRAME_OK, '0, '0);
                    end else begin
                        queue_event(EV_CHECK_ERR, '0, '0);
                    end
                    phase = RX_IDLE;
                end
                RX_SKIP_CMD, RX_SKIP_LEN: ;
                default: begin
                    frame_cmd = b;
                    frame_len = '0;
                    taken     = '0;
                    xor_acc   = b;
                    if (int'(b) >= int'(first_cmd) && int'(b) <= int'(first_cmd) + 4) begin
                        phase = RX_LENGTH;
                    end else if (b == resend_a || b == resend_b || b == resend_c) begin
                        phase = RX_IDLE;
                        queue_event(EV_RESEND, '0, '0);
                    end else begin
                        phase = RX_SKIP_CMD;
                    end
                end
            endcase
        end
    endtask

    always @(posedge aclk) begin
        rx_event_t due;
        if (!aresetn) begin
            phase           = RX_IDLE;
            first_cmd       = ResetFirstCmd;
            resend_a        = ResetResendA;
            resend_b        = ResetResendB;
            resend_c        = ResetResendC;
            frame_cmd       = '0;
            frame_len       = '0;
            xor_acc         = '0;
            taken           = '0;
            events_due      = {};
            mismatches      = 0;
            pending         = 0;
            results_checked = 0;
            frames_passed   = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FIRST_CMD: first_cmd = cfg_wdata;
                    REG_RESEND_A:  resend_a  = cfg_wdata;
                    REG_RESEND_B:  resend_b  = cfg_wdata;
                    REG_RESEND_C:  resend_c  = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results_checked++;
                if (m_event_kind === EV_FRAME_OK) begin
                    frames_passed++;
                end
                if (events_due.size() == 0) begin
                    flag_mismatch($sformatf("result kind %0d with nothing due", m_event_kind));
                end else begin
                    due = events_due.pop_front();
                    if (m_event_kind !== due.kind) begin
                        flag_mismatch($sformatf("event_kind %0d, expected %0d",
                                                m_event_kind, due.kind));
                    end
                    if (m_command_code !== due.cmd) begin
                        flag_mismatch($sformatf("command_code %h, expected %h",
                                                m_command_code, due.cmd));
                    end
                    if (m_frame_length !== due.len) begin
                        flag_mismatch($sformatf("frame_length %h, expected %h",
                                                m_frame_length, due.len));
                    end
                    if (m_payload_byte !== due.data) begin
                        flag_mismatch($sformatf("payload_byte %h, expected %h",
                                                m_payload_byte, due.data));
                    end
                    if (m_payload_index !== due.idx) begin
                        flag_mismatch($sformatf("payload_index %0d, expected %0d",
                                                m_payload_index, due.idx));
                    end
                end
            end
            if (s_valid && s_ready) begin
                parse_rx_transaction(opcode_t'(s_opcode), s_rx_byte);
            end
            pending = events_due.size();
        end
    end

endmodule

>>> test/tb_command_frame_receiver_xor_check_unit.sv
// Testbench top for command_frame_receiver_xor_check_unit: clock, reset, register
// settings, directed and random frame stimulus, result sink and verdict.
// Depends on cfrx_pkg and on cfrx_tb_pkg / cfrx_event_checker.
`timescale 1ns / 1ps

module tb_command_frame_receiver_xor_check_unit;
    import cfrx_pkg::*;
    import cfrx_tb_pkg::*;

    localparam int unsigned ItemsPerSetting = 52;
    localparam int unsigned MaxGap          = 18;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [RegIdxW-1:0] cfg_index = REG_FIRST_CMD;
    logic [ByteW-1:0]   cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_opcode  = OP_BYTE;
    logic [ByteW-1:0]   s_rx_byte = '0;
    logic               m_ready   = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic [KindW-1:0]   m_event_kind;
    logic [ByteW-1:0]   m_command_code;
    logic [ByteW-1:0]   m_frame_length;
    logic [ByteW-1:0]   m_payload_byte;
    logic [IndexW-1:0]  m_payload_index;

    int unsigned        mismatches;
    int unsigned        pending;
    int unsigned        results_checked;
    int unsigned        frames_passed;

    bit                 steady_source = 1'b0;
    bit                 steady_sink   = 1'b0;
    int unsigned        sink_wait;
    int unsigned        counted;
    int unsigned        sent;
    int unsigned        settings_run;
    logic [ByteW-1:0]   first_cmd;
    logic [ByteW-1:0]   resend_code [3];

    command_frame_receiver_xor_check_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_command_code  (m_command_code),
        .m_frame_length  (m_frame_length),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index)
    );

    cfrx_event_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_command_code  (m_command_code),
        .m_frame_length  (m_frame_length),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .frames_passed   (frames_passed)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hold m_ready low for a drawn number of cycles after each result
    always @(posedge aclk) begin
        int unsigned stall;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait <= 0;
        end else if (m_valid && m_ready) begin
            stall = steady_sink ? 0 : $urandom_range(0, MaxGap);
            sink_wait <= stall;
            m_ready   <= (stall == 0);
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_ready   <= (sink_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic bit is_command(input logic [ByteW-1:0] b);
        return int'(b) >= int'(first_cmd) && int'(b) <= int'(first_cmd) + int'(CMD_VERSION);
    endfunction

    task automatic send_item(input opcode_t op, input logic [ByteW-1:0] b, input bit counts);
        int unsigned gap;
        bit          took;
        gap = steady_source ? 0 : $urandom_range(0, MaxGap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_rx_byte <= b;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        sent++;
        if (counts) begin
            counted++;
        end
    endtask

    task automatic finish_outstanding();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_registers(input logic [ByteW-1:0] first, input logic [ByteW-1:0] a,
                                     input logic [ByteW-1:0] b, input logic [ByteW-1:0] c);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FIRST_CMD;
        cfg_wdata <= first;
        @(posedge aclk);
        cfg_index <= REG_RESEND_A;
        cfg_wdata <= a;
        @(posedge aclk);
        cfg_index <= REG_RESEND_B;
        cfg_wdata <= b;
        @(posedge aclk);
        cfg_index <= REG_RESEND_C;
        cfg_wdata <= c;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        first_cmd      = first;
        resend_code[0] = a;
        resend_code[1] = b;
        resend_code[2] = c;
    endtask

    // every frame ending, both error swallows and timeouts in each phase but the payload one
    task automatic directed_frames();
        logic [ByteW-1:0] cmd;
        steady_source = 1'b0;
        steady_sink   = 1'b0;
        cmd = first_cmd + CMD_SCAN;
        send_item(OP_BYTE, cmd, 1'b1);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_BYTE, cmd, 1'b1);
        cmd = first_cmd + CMD_VERSION;
        send_item(OP_BYTE, cmd, 1'b1);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_BYTE, ~cmd, 1'b1);
        send_item(OP_BYTE, resend_code[0], 1'b1);
        send_item(OP_BYTE, resend_code[1], 1'b1);
        send_item(OP_BYTE, resend_code[2], 1'b1);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_BYTE, 8'hff, 1'b0);
        send_item(OP_TIMEOUT, 8'h00, 1'b1);
        send_item(OP_TIMEOUT, 8'hff, 1'b1);
        send_item(OP_BYTE, first_cmd + CMD_SELECT, 1'b1);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_TIMEOUT, 8'h5a, 1'b1);
        send_item(OP_BYTE, first_cmd + CMD_READ, 1'b1);
        send_item(OP_TIMEOUT, 8'ha5, 1'b1);
        send_item(OP_BYTE, first_cmd + CMD_SCAN, 1'b1);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_TIMEOUT, 8'h00, 1'b1);
        send_item(OP_BYTE, first_cmd + CMD_WRITE, 1'b1);
        send_item(OP_BYTE, 8'h00, 1'b1);
        send_item(OP_TIMEOUT, 8'hff, 1'b1);
    endtask

    task automatic random_sequence();
        logic [ByteW-1:0] frame[$];
        logic [ByteW-1:0] len;
        logic [ByteW-1:0] chk;
        logic [ByteW-1:0] b;
        command_t         which;
        int unsigned      pick;
        int unsigned      cut;
        int unsigned      max_offset;
        frame         = {};
        steady_source = ($urandom_range(0, 3) == 0);
        steady_sink   = ($urandom_range(0, 3) == 0);
        pick          = $urandom_range(0, 99);
        max_offset    = (255 - int'(first_cmd) < int'(CMD_VERSION)) ?
                        255 - int'(first_cmd) : int'(CMD_VERSION);
        which         = command_t'($urandom_range(0, max_offset));
        if (pick < 55) begin
            case (which)
                CMD_SELECT: len = LenSelect;
                CMD_READ:   len = LenRead;
                CMD_WRITE: begin
                    case ($urandom_range(0, 3))
                        0:       len = LenWriteMin;
                        1:       len = LenWriteMax;
                        default: len = $urandom_range(LenWriteMin, LenWriteMax);
                    endcase
                end
                default:    len = '0;
            endcase
            frame.push_back(first_cmd + which);
            frame.push_back(len);
            repeat (len) frame.push_back($urandom_range(0, 255));
            chk = '0;
            foreach (frame[i]) chk = chk ^ frame[i];
            if ($urandom_range(0, 6) == 0) begin
                chk = chk ^ $urandom_range(1, 255);
            end
            frame.push_back(chk);
            cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, frame.size() - 1) : frame.size();
            foreach (frame[i]) begin
                if (i < cut) begin
                    send_item(OP_BYTE, frame[i], 1'b1);
                end
            end
            if (cut < frame.size()) begin
                send_item(OP_TIMEOUT, $urandom_range(0, 255), 1'b1);
            end
        end else if (pick < 65) begin
            b = resend_code[$urandom_range(0, 2)];
            send_item(OP_BYTE, b, 1'b1);
            if (is_command(b)) begin
                send_item(OP_TIMEOUT, $urandom_range(0, 255), 1'b1);
            end
        end else if (pick < 85) begin
            if (pick < 75) begin
                case (which)
                    CMD_SELECT: len = ($urandom_range(0, 1) != 0) ? LenSelect + 1 : LenSelect - 1;
                    CMD_READ:   len = ($urandom_range(0, 1) != 0) ? LenRead + 1 : 8'hff;
                    CMD_WRITE: begin
                        case ($urandom_range(0, 3))
                            0:       len = LenWriteMin - 1;
                            1:       len = LenWriteMax + 1;
                            2:       len = $urandom_range(0, LenWriteMin - 1);
                            default: len = $urandom_range(LenWriteMax + 1, 255);
                        endcase
                    end
                    default:    len = ($urandom_range(0, 1) != 0) ? 8'hff : $urandom_range(1, 255);
                endcase
                send_item(OP_BYTE, first_cmd + which, 1'b1);
                send_item(OP_BYTE, len, 1'b1);
            end else begin
                do b = $urandom_range(0, 255);
                while (is_command(b) || b == resend_code[0] || b == resend_code[1] ||
                       b == resend_code[2]);
                send_item(OP_BYTE, b, 1'b1);
            end
            repeat ($urandom_range(0, 3)) send_item(OP_BYTE, $urandom_range(0, 255), 1'b0);
            send_item(OP_TIMEOUT, $urandom_range(0, 255), 1'b1);
        end else begin
            repeat ($urandom_range(1, 3)) begin
                send_item(opcode_t'($urandom_range(0, 1)), $urandom_range(0, 255), 1'b0);
            end
        end
        if ($urandom_range(0, 39) == 0) begin
            finish_outstanding();
        end
    endtask

    initial begin
        first_cmd      = ResetFirstCmd;
        resend_code[0] = ResetResendA;
        resend_code[1] = ResetResendB;
        resend_code[2] = ResetResendC;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int unsigned setting = 0; setting < 6; setting++) begin
            case (setting)
                1: program_registers(8'd0, 8'd0, 8'd255, 8'd3);
                2: program_registers(8'd251, 8'd255, 8'd128, 8'd0);
                3: program_registers(8'd253, 8'd252, 8'd254, 8'd17);
                4: program_registers($urandom_range(0, 251), $urandom_range(0, 255),
                                     $urandom_range(0, 255), $urandom_range(0, 255));
                5: program_registers(ResetFirstCmd, ResetResendA, ResetResendB, ResetResendC);
                default: directed_frames();
            endcase
            settings_run++;
            counted = 0;
            while (counted < ItemsPerSetting) begin
                random_sequence();
            end
            finish_outstanding();
        end
        repeat (8) @(posedge aclk);
        $display("Covered %0d transactions over %0d register settings: directed cases, %s",
                 sent, settings_run, "random frames, broken frames and noise.");
        $display("Checked %0d results; %0d frames closed with a good checksum.",
                 results_checked, frames_passed);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
